// File: hw/rtl/mrme_pkg.sv
// ----------------------------------------------------------------------------
// Maze region merge engine package
// Shared widths, command codes, labels and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package mrme_pkg;

   localparam int FUNC_W  = 2;
   localparam int COORD_W = 6;
   localparam int DIR_W   = 2;
   localparam int VAL_W   = 11;
   localparam int LABEL_W = 10;
   localparam int CNT_W   = 10;
   localparam int CSR_W   = 6;
   localparam int CSR_IDX_W = 1;

   localparam int DEF_MAX_ROWS = 63;
   localparam int DEF_MAX_COLS = 63;

   localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_MERGE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   localparam logic [CSR_W-1:0] CSR_RESET = 6'd63;
   localparam logic [CSR_W-1:0] MIN_SIZE  = 6'd3;

   localparam logic [VAL_W-1:0] WALL_LABEL     = 11'h000;
   localparam logic [VAL_W-1:0] ENTRANCE_LABEL = 11'h7FF;
   localparam logic [VAL_W-1:0] EXIT_LABEL     = 11'h7FE;

   localparam logic [CNT_W-1:0] MERGE_MAX = 10'd1023;

   typedef enum logic [1:0] {
      RD_ROOM = 2'd0,
      RD_NBR  = 2'd1,
      RD_SCAN = 2'd2,
      RD_CELL = 2'd3
   } rd_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       sweep_wr;
      logic       sweep_zero;
      rd_sel_type rd_sel;
      logic       cap_val;
      logic       cap_target;
      logic       wall_wr;
      logic       scan_wr;
      logic       merge_ok;
      logic       init_done;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic merge_legal;
      logic same_label;
      logic sweep_end;
      logic scan_end;
      logic out_free;
   } status_type;

endpackage

// File: hw/rtl/mrme_ctrl.sv
// ----------------------------------------------------------------------------
// Maze region merge engine controller
// Sequences clearing, init sweeps, merge lookups, relabel scans and results.
// ----------------------------------------------------------------------------
module mrme_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mrme_pkg::FUNC_W-1:0]  req_func,
   input  mrme_pkg::status_type         status,
   output mrme_pkg::cmd_type            cmd
);
   import mrme_pkg::*;

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b00_0000_0001,
      ST_IDLE   = 10'b00_0000_0010,
      ST_INIT   = 10'b00_0000_0100,
      ST_ROOM   = 10'b00_0000_1000,
      ST_NBR    = 10'b00_0001_0000,
      ST_CHECK  = 10'b00_0010_0000,
      ST_WALL   = 10'b00_0100_0000,
      ST_SCAN   = 10'b00_1000_0000,
      ST_CELL   = 10'b01_0000_0000,
      ST_RESULT = 10'b10_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_sel = RD_CELL;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_wr   = 1'b1;
            cmd.sweep_zero = 1'b1;
            cmd.cnt_inc    = 1'b1;
            if (status.sweep_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.cnt_clr  = 1'b1;
               case (req_func)
                  FUNC_INIT:  state_in = ST_INIT;
                  FUNC_MERGE: state_in = ST_ROOM;
                  default:    state_in = ST_CELL;
               endcase
            end
         end
         ST_INIT: begin
            cmd.sweep_wr = 1'b1;
            cmd.cnt_inc  = 1'b1;
            if (status.sweep_end) begin
               cmd.init_done = 1'b1;
               state_in      = ST_CELL;
            end
         end
         ST_ROOM: begin
            cmd.rd_sel = RD_ROOM;
            if (status.merge_legal) begin
               state_in = ST_NBR;
            end else begin
               state_in = ST_CELL;
            end
         end
         ST_NBR: begin
            cmd.rd_sel  = RD_NBR;
            cmd.cap_val = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.cap_target = 1'b1;
            if (status.same_label) begin
               state_in = ST_CELL;
            end else begin
               state_in = ST_WALL;
            end
         end
         ST_WALL: begin
            cmd.wall_wr = 1'b1;
            cmd.cnt_clr = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.rd_sel  = RD_SCAN;
            cmd.scan_wr = 1'b1;
            if (status.scan_end) begin
               cmd.merge_ok = 1'b1;
               state_in     = ST_CELL;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_CELL: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// File: hw/rtl/mrme_datapath.sv
// ----------------------------------------------------------------------------
// Maze region merge engine datapath
// Grid memory, sweep counter, size registers, merge checks and result register.
// ----------------------------------------------------------------------------
module mrme_datapath #(
   parameter int MAX_ROWS = mrme_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = mrme_pkg::DEF_MAX_COLS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mrme_pkg::cmd_type                   cmd,
   output mrme_pkg::status_type                status,
   input  logic [mrme_pkg::FUNC_W-1:0]         req_func,
   input  logic [mrme_pkg::COORD_W-1:0]        req_row,
   input  logic [mrme_pkg::COORD_W-1:0]        req_col,
   input  logic [mrme_pkg::DIR_W-1:0]          req_dir,
   input  logic                                csr_wr,
   input  logic [mrme_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mrme_pkg::CSR_W-1:0]          csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_success,
   output logic signed [mrme_pkg::VAL_W-1:0]   rsp_cell_value,
   output logic                                rsp_done_res
);
   import mrme_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int AW    = RW + CW;
   localparam int DEPTH = 1 << AW;
   localparam logic [COORD_W-1:0] ROWS_MAX = COORD_W'(MAX_ROWS);
   localparam logic [COORD_W-1:0] COLS_MAX = COORD_W'(MAX_COLS);

   logic [VAL_W-1:0]   grid_ff [DEPTH];
   logic [VAL_W-1:0]   rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VAL_W-1:0]   wr_data;

   logic [AW:0]        cnt_ff;
   logic [LABEL_W-1:0] label_ff;
   logic [CSR_W-1:0]   rows_cfg_ff;
   logic [CSR_W-1:0]   cols_cfg_ff;
   logic [FUNC_W-1:0]  func_ff;
   logic [COORD_W-1:0] row_ff;
   logic [COORD_W-1:0] col_ff;
   logic [DIR_W-1:0]   dir_ff;
   logic [VAL_W-1:0]   val_ff;
   logic [VAL_W-1:0]   target_ff;
   logic               ok_ff;
   logic [CNT_W-1:0]   merges_ff;

   logic               rsp_valid_ff;
   logic               success_ff;
   logic [VAL_W-1:0]   cell_ff;
   logic               done_ff;

   logic [COORD_W-1:0] rows_eff;
   logic [COORD_W-1:0] cols_eff;
   logic               in_grid;
   logic               dir_ok;
   logic [COORD_W-1:0] nbr_r;
   logic [COORD_W-1:0] nbr_c;
   logic [COORD_W-1:0] wall_r;
   logic [COORD_W-1:0] wall_c;
   logic [COORD_W-1:0] sw_r;
   logic [COORD_W-1:0] sw_c;
   logic               sw_room;
   logic [VAL_W-1:0]   sw_val;
   logic [AW-1:0]      cell_addr;
   logic [LABEL_W-1:0] rooms;
   logic               success_in;
   logic               out_free;

   function automatic logic [COORD_W-1:0] eff_size(input logic [CSR_W-1:0] v,
                                                   input logic [COORD_W-1:0] maxv);
      logic [COORD_W-1:0] s;
      s = v;
      if (s < MIN_SIZE) s = MIN_SIZE;
      if (s > maxv) s = maxv;
      if (!s[0]) s = s - 1'b1;
      return s;
   endfunction

   assign rows_eff  = eff_size(rows_cfg_ff, ROWS_MAX);
   assign cols_eff  = eff_size(cols_cfg_ff, COLS_MAX);
   assign in_grid   = (row_ff < rows_eff) && (col_ff < cols_eff);
   assign cell_addr = {row_ff[RW-1:0], col_ff[CW-1:0]};

   always_comb begin
      nbr_r  = row_ff;
      nbr_c  = col_ff;
      wall_r = row_ff;
      wall_c = col_ff;
      dir_ok = 1'b0;
      case (dir_ff)
         DIR_UP: begin
            dir_ok = row_ff > 6'd2;
            nbr_r  = row_ff - 6'd2;
            wall_r = row_ff - 6'd1;
         end
         DIR_RIGHT: begin
            dir_ok = ({1'b0, col_ff} + 7'd2) < {1'b0, cols_eff};
            nbr_c  = col_ff + 6'd2;
            wall_c = col_ff + 6'd1;
         end
         DIR_DOWN: begin
            dir_ok = ({1'b0, row_ff} + 7'd2) < {1'b0, rows_eff};
            nbr_r  = row_ff + 6'd2;
            wall_r = row_ff + 6'd1;
         end
         default: begin
            dir_ok = col_ff > 6'd2;
            nbr_c  = col_ff - 6'd2;
            wall_c = col_ff - 6'd1;
         end
      endcase
   end

   assign status.merge_legal = row_ff[0] && col_ff[0] && (row_ff < rows_eff - 6'd1)
                               && (col_ff < cols_eff - 6'd1) && dir_ok;
   assign status.same_label  = rd_data_ff == val_ff;
   assign status.sweep_end   = cnt_ff[AW-1:0] == {AW{1'b1}};
   assign status.scan_end    = cnt_ff == (AW+1)'(DEPTH);
   assign status.out_free    = out_free;

   assign sw_r    = COORD_W'(cnt_ff[AW-1:CW]);
   assign sw_c    = COORD_W'(cnt_ff[CW-1:0]);
   assign sw_room = sw_r[0] && sw_c[0] && (sw_r < rows_eff - 6'd1)
                    && (sw_c < cols_eff - 6'd1);

   always_comb begin
      if (cmd.sweep_zero) begin
         sw_val = WALL_LABEL;
      end else if (sw_r == 6'd0 && sw_c == 6'd1) begin
         sw_val = ENTRANCE_LABEL;
      end else if (sw_r == rows_eff - 6'd1 && sw_c == cols_eff - 6'd2) begin
         sw_val = EXIT_LABEL;
      end else if (sw_room) begin
         sw_val = {1'b0, label_ff};
      end else begin
         sw_val = WALL_LABEL;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_ROOM: rd_addr = cell_addr;
         RD_NBR:  rd_addr = {nbr_r[RW-1:0], nbr_c[CW-1:0]};
         RD_SCAN: rd_addr = cnt_ff[AW-1:0];
         RD_CELL: rd_addr = cell_addr;
         default: rd_addr = cell_addr;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[AW-1:0];
      wr_data = sw_val;
      if (cmd.sweep_wr) begin
         wr_en = 1'b1;
      end else if (cmd.wall_wr) begin
         wr_en   = 1'b1;
         wr_addr = {wall_r[RW-1:0], wall_c[CW-1:0]};
         wr_data = val_ff;
      end else if (cmd.scan_wr) begin
         wr_en   = (cnt_ff != '0) && (rd_data_ff == target_ff);
         wr_addr = AW'(cnt_ff - 1'b1);
         wr_data = val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= grid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         label_ff    <= LABEL_W'(1);
         rows_cfg_ff <= CSR_RESET;
         cols_cfg_ff <= CSR_RESET;
         ok_ff       <= 1'b0;
         merges_ff   <= '0;
      end else begin
         if (cmd.cnt_clr) begin
            cnt_ff   <= '0;
            label_ff <= LABEL_W'(1);
         end else begin
            if (cmd.cnt_inc) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (cmd.sweep_wr && !cmd.sweep_zero && sw_room) begin
               label_ff <= label_ff + 1'b1;
            end
         end
         if (csr_wr) begin
            case (csr_index)
               CSR_ROWS: rows_cfg_ff <= csr_data;
               CSR_COLS: cols_cfg_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.load_req) begin
            ok_ff <= 1'b0;
         end else if (cmd.merge_ok) begin
            ok_ff <= 1'b1;
         end
         if (cmd.init_done) begin
            merges_ff <= '0;
         end else if (cmd.merge_ok && merges_ff != MERGE_MAX) begin
            merges_ff <= merges_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         row_ff  <= req_row;
         col_ff  <= req_col;
         dir_ff  <= req_dir;
      end
      if (cmd.cap_val) begin
         val_ff <= rd_data_ff;
      end
      if (cmd.cap_target) begin
         target_ff <= rd_data_ff;
      end
   end

   assign rooms = LABEL_W'(rows_eff[COORD_W-1:1] * cols_eff[COORD_W-1:1]);

   always_comb begin
      case (func_ff)
         FUNC_INIT:  success_in = 1'b1;
         FUNC_MERGE: success_in = ok_ff;
         FUNC_READ:  success_in = in_grid;
         default:    success_in = 1'b0;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         success_ff <= success_in;
         cell_ff    <= in_grid ? rd_data_ff : WALL_LABEL;
         done_ff    <= ({1'b0, merges_ff} + 11'd1) >= {1'b0, rooms};
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_success    = success_ff;
   assign rsp_cell_value = $signed(cell_ff);
   assign rsp_done_res   = done_ff;

endmodule

// File: hw/rtl/maze_region_merge_engine_top.sv
// ----------------------------------------------------------------------------
// Maze region merge engine top level
// Grid label store for randomized Kruskal maze generation.
// ----------------------------------------------------------------------------
// One command is handled at a time, and an item is accepted only while the
// engine is idle. An init makes one write pass over the whole grid memory at
// one cell per cycle. A merge with bad coordinates, or whose two rooms already
// share a label, ends without writing. A successful merge adds the wall write
// and a relabel scan over the whole grid memory. The next item is accepted at
// the edge after rsp_valid rises. A result enters the output register only
// once the previous one has been taken, so a stalled receiver stalls the
// engine. After reset the grid memory is cleared to walls in one write pass,
// during which no item is accepted; configuration writes are taken at any time.
module maze_region_merge_engine_top #(
   parameter int MAX_ROWS = mrme_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = mrme_pkg::DEF_MAX_COLS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mrme_pkg::FUNC_W-1:0]         req_func,
   input  logic [mrme_pkg::COORD_W-1:0]        req_row,
   input  logic [mrme_pkg::COORD_W-1:0]        req_col,
   input  logic [mrme_pkg::DIR_W-1:0]          req_dir,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_success,
   output logic signed [mrme_pkg::VAL_W-1:0]   rsp_cell_value,
   output logic                                rsp_done_res,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mrme_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mrme_pkg::CSR_W-1:0]          csr_data
);
   import mrme_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mrme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd)
   );

   mrme_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req_func),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_dir        (req_dir),
      .csr_wr         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_success    (rsp_success),
      .rsp_cell_value (rsp_cell_value),
      .rsp_done_res   (rsp_done_res)
   );

endmodule

// File: hw/rtl/mrme_checker.sv
// ----------------------------------------------------------------------------
// Maze region merge engine checker
// Port-level properties of the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module mrme_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_success,
   input logic signed [mrme_pkg::VAL_W-1:0]   rsp_cell_value,
   input logic                                rsp_done_res
);
   import mrme_pkg::*;

   // A stalled result item must hold its fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value)
      && $stable(rsp_success) && $stable(rsp_done_res))
      else $error("result item changed while stalled");

   // The engine works on one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a command was in progress");

   // Cell labels stay between the exit marker and the largest room label.
   a_label_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cell_value >= -11'sd2 && rsp_cell_value <= 11'sd961)
      else $error("cell label out of range");

endmodule

bind maze_region_merge_engine_top mrme_checker u_mrme_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_success    (rsp_success),
   .rsp_cell_value (rsp_cell_value),
   .rsp_done_res   (rsp_done_res)
);
